// File: rtl/wps_pkg.sv
`default_nettype none

package wps_pkg;

    // Fixed widths of the item fields.
    localparam int COORD_W = 8;
    localparam int SLOT_W  = 5;
    localparam int COUNT_W = 6;

    // Score that means "no box found yet".
    localparam logic [COORD_W-1:0] SCORE_NONE = 8'hFF;

    // The edge search gives up after this many halvings.
    localparam int SEARCH_STEPS = 16;
    localparam int STEP_W       = $clog2(SEARCH_STEPS);

    // Function codes of an input word.
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_SNAP = 1'b1;

    typedef struct packed {
        logic [COORD_W-1:0] top;
        logic [COORD_W-1:0] bot;
        logic [COORD_W-1:0] ulx;
        logic [COORD_W-1:0] urx;
        logic [COORD_W-1:0] llx;
        logic [COORD_W-1:0] lrx;
    } t_box;

    typedef struct packed {
        logic               done;
        logic [COORD_W-1:0] score;
        logic [COORD_W-1:0] cx;
        logic [COORD_W-1:0] cy;
    } t_eval_res;

endpackage

`default_nettype wire

// File: rtl/wps_if.sv
`default_nettype none

interface wps_in_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [4:0] slot;
    logic [7:0] upper_left_x;
    logic [7:0] upper_right_x;
    logic [7:0] lower_left_x;
    logic [7:0] lower_right_x;
    logic [7:0] top_y;
    logic [7:0] bottom_y;
    logic [7:0] point_x;
    logic [7:0] point_y;

    modport source (
        output valid, func, slot, upper_left_x, upper_right_x, lower_left_x,
               lower_right_x, top_y, bottom_y, point_x, point_y,
        input  ready
    );

    modport sink (
        input  valid, func, slot, upper_left_x, upper_right_x, lower_left_x,
               lower_right_x, top_y, bottom_y, point_x, point_y,
        output ready
    );
endinterface

interface wps_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] snapped_x;
    logic [7:0] snapped_y;
    logic [4:0] box_index;
    logic       found;

    modport source (
        output valid, snapped_x, snapped_y, box_index, found,
        input  ready
    );

    modport sink (
        input  valid, snapped_x, snapped_y, box_index, found,
        output ready
    );
endinterface

`default_nettype wire

// File: rtl/wps_box_mem.sv
`default_nettype none

module wps_box_mem
    import wps_pkg::*;
#(
    parameter int DEPTH = 32,
    parameter int IW    = 5
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [IW-1:0] i_waddr,
    input  wire t_box          i_wdata,
    input  wire logic [IW-1:0] i_raddr,
    output t_box               o_rdata
);

    t_box r_mem [DEPTH];
    t_box r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: rtl/wps_box_eval.sv
`default_nettype none

module wps_box_eval
    import wps_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire t_box               i_box,
    input  wire logic [COORD_W-1:0] i_px,
    input  wire logic [COORD_W-1:0] i_py,
    output t_eval_res               o_res
);

    typedef enum logic [1:0] {
        E_IDLE,
        E_SEARCH,
        E_SCORE
    } t_estate;

    t_estate            r_state;
    t_eval_res          r_res;
    logic [COORD_W-1:0] r_ul, r_ur, r_ll, r_lr, r_t, r_bt;
    logic [COORD_W-1:0] r_lo, r_hi, r_ry;
    logic [STEP_W-1:0]  r_k;

    logic [COORD_W:0]   n_lo_sum, n_hi_sum, n_mid_sum;
    logic [COORD_W-1:0] n_lo, n_hi, n_mid;
    logic [COORD_W-1:0] n_rx, n_dx, n_dyfull, n_dy;
    logic [COORD_W:0]   n_score;
    logic               n_inside;

    // One halving step of the edge search: midpoints of both edges and of y.
    always_comb begin
        n_lo_sum  = {1'b0, r_ul} + {1'b0, r_ll};
        n_hi_sum  = {1'b0, r_ur} + {1'b0, r_lr};
        n_mid_sum = {1'b0, r_t} + {1'b0, r_bt};
        n_lo      = n_lo_sum[COORD_W:1];
        n_hi      = n_hi_sum[COORD_W:1];
        n_mid     = n_mid_sum[COORD_W:1];
    end

    assign n_inside = (i_px >= i_box.ulx) && (i_px >= i_box.llx)
                   && (i_px < i_box.urx) && (i_px < i_box.lrx);

    // Clamp and octagonal distance. An inverted interval favors its low end.
    always_comb begin
        if (i_px < r_lo) begin
            n_rx = r_lo;
        end else if (i_px > r_hi) begin
            n_rx = r_hi;
        end else begin
            n_rx = i_px;
        end
        n_dx     = (i_px > n_rx) ? (i_px - n_rx) : (n_rx - i_px);
        n_dyfull = (i_py > r_ry) ? (i_py - r_ry) : (r_ry - i_py);
        n_dy     = n_dyfull >> 2;
        if (n_dx < n_dy) begin
            n_score = {2'b0, n_dx[COORD_W-1:1]} + {1'b0, n_dy};
        end else begin
            n_score = {2'b0, n_dy[COORD_W-1:1]} + {1'b0, n_dx};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= E_IDLE;
            r_res.done <= 1'b0;
        end else begin
            case (r_state)
                E_IDLE: begin
                    r_res.done <= 1'b0;
                    if (i_start) begin
                        r_k <= '0;
                        if (i_py < i_box.top) begin
                            r_ry    <= i_box.top;
                            r_lo    <= i_box.ulx;
                            r_hi    <= i_box.urx;
                            r_state <= E_SCORE;
                        end else if (i_py >= i_box.bot) begin
                            r_ry    <= i_box.bot;
                            r_lo    <= i_box.llx;
                            r_hi    <= i_box.lrx;
                            r_state <= E_SCORE;
                        end else if (n_inside) begin
                            r_ry    <= i_py;
                            r_lo    <= i_px;
                            r_hi    <= i_px;
                            r_state <= E_SCORE;
                        end else begin
                            r_ry    <= i_py;
                            r_ul    <= i_box.ulx;
                            r_ur    <= i_box.urx;
                            r_ll    <= i_box.llx;
                            r_lr    <= i_box.lrx;
                            r_t     <= i_box.top;
                            r_bt    <= i_box.bot;
                            r_state <= E_SEARCH;
                        end
                    end
                end
                E_SEARCH: begin
                    r_res.done <= 1'b0;
                    r_lo <= n_lo;
                    r_hi <= n_hi;
                    r_k  <= r_k + 1'b1;
                    if (n_mid < i_py) begin
                        r_t  <= n_mid;
                        r_ul <= n_lo;
                        r_ur <= n_hi;
                    end else if (n_mid > i_py) begin
                        r_bt <= n_mid;
                        r_ll <= n_lo;
                        r_lr <= n_hi;
                    end
                    if ((n_mid == i_py) || (r_k == STEP_W'(SEARCH_STEPS - 1))) begin
                        r_state <= E_SCORE;
                    end
                end
                E_SCORE: begin
                    r_res.done  <= 1'b1;
                    r_res.score <= n_score[COORD_W-1:0];
                    r_res.cx    <= n_rx;
                    r_res.cy    <= r_ry;
                    r_state     <= E_IDLE;
                end
                default: begin
                    r_res.done <= 1'b0;
                    r_state    <= E_IDLE;
                end
            endcase
        end
    end

    assign o_res = r_res;

endmodule

`default_nettype wire

// File: rtl/walkbox_point_snap_core.sv
`default_nettype none

// Walk box point snapper. A load word (func 0) writes one box into the table
// and returns nothing. A snap word (func 1) visits the boxes from box_count-1
// down to 0 and returns one word with the closest point of the best box. Each
// box costs a table read, a setup step, up to SEARCH_STEPS edge search steps in
// the shared evaluator (the row of the point is always hit by then), a scoring
// step and a handoff; the search steps are only needed when the point lies
// beside the box, not above, below or inside it. The walk ends early on a box
// that scores zero. The input is not ready while a snap is in progress or its
// result waits on the output. The table is undefined until written; box_count
// must only name loaded slots.

module walkbox_point_snap_core
    import wps_pkg::*;
#(
    parameter int BOX_SLOTS = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [COUNT_W-1:0] i_cfg_wdata,
    wps_in_if.sink                  i_in,
    wps_out_if.source               o_out
);

    localparam int IW = (BOX_SLOTS > 1) ? $clog2(BOX_SLOTS) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_EVAL,
        S_RUN,
        S_OUT
    } t_state;

    t_state             r_state;
    logic [COUNT_W-1:0] r_box_count;
    logic [IW-1:0]      r_idx;
    logic [IW-1:0]      r_bi;
    logic [COORD_W-1:0] r_px, r_py, r_ox, r_oy, r_best;
    logic               r_hit;

    logic               n_accept;
    logic               n_we;
    logic [COUNT_W:0]   n_count;
    t_box               n_wbox;
    t_box               n_rbox;
    t_eval_res          n_res;

    assign n_accept = i_in.valid && i_in.ready;
    assign n_we     = n_accept && (i_in.func == FUNC_LOAD)
                   && ({3'b0, i_in.slot} < 8'(BOX_SLOTS));

    // Boxes in use, saturated to the table size.
    always_comb begin
        if ({1'b0, r_box_count} > (COUNT_W + 1)'(BOX_SLOTS)) begin
            n_count = (COUNT_W + 1)'(BOX_SLOTS);
        end else begin
            n_count = {1'b0, r_box_count};
        end
    end

    always_comb begin
        n_wbox.top = i_in.top_y;
        n_wbox.bot = i_in.bottom_y;
        n_wbox.ulx = i_in.upper_left_x;
        n_wbox.urx = i_in.upper_right_x;
        n_wbox.llx = i_in.lower_left_x;
        n_wbox.lrx = i_in.lower_right_x;
    end

    wps_box_mem #(
        .DEPTH (BOX_SLOTS),
        .IW    (IW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (n_we),
        .i_waddr (IW'(i_in.slot)),
        .i_wdata (n_wbox),
        .i_raddr (r_idx),
        .o_rdata (n_rbox)
    );

    wps_box_eval u_eval (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_EVAL),
        .i_box   (n_rbox),
        .i_px    (r_px),
        .i_py    (r_py),
        .o_res   (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_box_count <= '0;
            r_hit       <= 1'b0;
            r_bi        <= '0;
            r_idx       <= '0;
        end else begin
            if (i_cfg_we) begin
                r_box_count <= i_cfg_wdata;
            end
            case (r_state)
                S_IDLE: begin
                    if (n_accept && (i_in.func == FUNC_SNAP)) begin
                        r_px   <= i_in.point_x;
                        r_py   <= i_in.point_y;
                        r_ox   <= i_in.point_x;
                        r_oy   <= i_in.point_y;
                        r_best <= SCORE_NONE;
                        r_hit  <= 1'b0;
                        r_bi   <= '0;
                        r_idx  <= IW'(n_count - 1'b1);
                        if (n_count == '0) begin
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_READ;
                        end
                    end
                end
                S_READ: begin
                    r_state <= S_EVAL;
                end
                S_EVAL: begin
                    r_state <= S_RUN;
                end
                S_RUN: begin
                    if (n_res.done) begin
                        if (n_res.score < r_best) begin
                            r_best <= n_res.score;
                            r_ox   <= n_res.cx;
                            r_oy   <= n_res.cy;
                            r_bi   <= r_idx;
                            r_hit  <= 1'b1;
                        end
                        // A perfect score ends the walk at once.
                        if ((n_res.score == '0) || (r_idx == '0)) begin
                            r_state <= S_OUT;
                        end else begin
                            r_idx   <= r_idx - 1'b1;
                            r_state <= S_READ;
                        end
                    end
                end
                S_OUT: begin
                    if (o_out.ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_in.ready      = (r_state == S_IDLE);
    assign o_out.valid     = (r_state == S_OUT);
    assign o_out.snapped_x = r_ox;
    assign o_out.snapped_y = r_oy;
    assign o_out.box_index = SLOT_W'(r_bi);
    assign o_out.found     = r_hit;

endmodule

`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import wps_pkg::*;

    localparam int BOX_SLOTS   = 32;
    localparam int SETTLE      = 16;
    localparam int LONG_HOLD   = 400;
    localparam int PHASES      = 9;
    localparam int PHASE_ITEMS = 55;

    typedef struct packed {
        logic               func;
        logic [SLOT_W-1:0]  slot;
        logic [COORD_W-1:0] ulx, urx, llx, lrx, top, bot, px, py;
    } t_in_word;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [SLOT_W-1:0]  index;
        logic               found;
    } t_snap_res;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               cfg_we    = 1'b0;
    logic [COUNT_W-1:0] cfg_wdata = '0;

    wps_in_if  in_if ();
    wps_out_if out_if ();

    walkbox_point_snap_core #(
        .BOX_SLOTS (BOX_SLOTS)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    t_box      box_mem [BOX_SLOTS];
    int        box_count_q = 0;
    t_in_word  pending_words [$];
    t_snap_res expected_snaps [$];
    t_in_word  offered_word;
    int        fail_count   = 0;
    int        send_gap_pct = 26;
    int        recv_gap_pct = 69;
    logic      rx_hold      = 1'b0;
    bit        hold_go      = 1'b0;

    always #5 clk = ~clk;

    initial begin
        in_if.valid         = 1'b0;
        in_if.func          = FUNC_LOAD;
        in_if.slot          = '0;
        in_if.upper_left_x  = '0;
        in_if.upper_right_x = '0;
        in_if.lower_left_x  = '0;
        in_if.lower_right_x = '0;
        in_if.top_y         = '0;
        in_if.bottom_y      = '0;
        in_if.point_x       = '0;
        in_if.point_y       = '0;
        out_if.ready        = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Closest point of one box and its octagonal distance score.
    function automatic void score_box(input t_box b, input int x, input int y,
                                      output int score, output int cx, output int cy);
        int lo, hi, ul, ll, ur, lr, t, bt, mid, dx, dy, sum, k;
        bit halt;
        lo = 0;
        hi = 0;
        cy = y;
        if (y < b.top) begin
            cy = b.top;
            lo = b.ulx;
            hi = b.urx;
        end else if (y >= b.bot) begin
            cy = b.bot;
            lo = b.llx;
            hi = b.lrx;
        end else if (x >= b.ulx && x >= b.llx && x < b.urx && x < b.lrx) begin
            lo = x;
            hi = x;
        end else begin
            // Halve the box toward the row of the point until a midline hits it.
            ul   = b.ulx;
            ll   = b.llx;
            ur   = b.urx;
            lr   = b.lrx;
            t    = b.top;
            bt   = b.bot;
            halt = 1'b0;
            for (k = 0; k < SEARCH_STEPS; k++) begin
                if (!halt) begin
                    lo  = (ul + ll) / 2;
                    hi  = (ur + lr) / 2;
                    mid = (t + bt) / 2;
                    if (mid < y) begin
                        t  = mid;
                        ul = lo;
                        ur = hi;
                    end else if (mid > y) begin
                        bt = mid;
                        ll = lo;
                        lr = hi;
                    end else begin
                        halt = 1'b1;
                    end
                end
            end
        end
        // An inverted interval resolves toward its lower bound first.
        if (x < lo) cx = lo;
        else if (x > hi) cx = hi;
        else cx = x;
        dx  = (x > cx) ? x - cx : cx - x;
        dy  = ((y > cy) ? y - cy : cy - y) / 4;
        sum = (dx < dy) ? (dx >> 1) + dy : (dy >> 1) + dx;
        score = sum & 255;
    endfunction

    function automatic t_snap_res snap_point(input int px, input int py);
        t_snap_res r;
        int n, best, sc, cx, cy, i;
        bit stop;
        r.x     = COORD_W'(px);
        r.y     = COORD_W'(py);
        r.index = '0;
        r.found = 1'b0;
        best    = SCORE_NONE;
        stop    = 1'b0;
        n = (box_count_q > BOX_SLOTS) ? BOX_SLOTS : box_count_q;
        for (i = n - 1; i >= 0; i--) begin
            if (!stop) begin
                score_box(box_mem[i], px, py, sc, cx, cy);
                // Strict compare: on a tie the higher index, seen first, stays.
                if (sc < best) begin
                    best    = sc;
                    r.x     = COORD_W'(cx);
                    r.y     = COORD_W'(cy);
                    r.index = SLOT_W'(i);
                    r.found = 1'b1;
                    stop    = (sc == 0);
                end
            end
        end
        return r;
    endfunction

    function automatic void accept_word(input t_in_word w);
        if (w.func == FUNC_LOAD) begin
            box_mem[w.slot].top = w.top;
            box_mem[w.slot].bot = w.bot;
            box_mem[w.slot].ulx = w.ulx;
            box_mem[w.slot].urx = w.urx;
            box_mem[w.slot].llx = w.llx;
            box_mem[w.slot].lrx = w.lrx;
        end else begin
            expected_snaps.push_back(snap_point(w.px, w.py));
        end
    endfunction

    // Driver: predicts each word at the edge that accepts it.
    always @(posedge clk) begin
        if (!rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                accept_word(offered_word);
            end
            if (!(in_if.valid && !in_if.ready)) begin
                if (pending_words.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                    offered_word = pending_words.pop_front();
                    in_if.func          <= offered_word.func;
                    in_if.slot          <= offered_word.slot;
                    in_if.upper_left_x  <= offered_word.ulx;
                    in_if.upper_right_x <= offered_word.urx;
                    in_if.lower_left_x  <= offered_word.llx;
                    in_if.lower_right_x <= offered_word.lrx;
                    in_if.top_y         <= offered_word.top;
                    in_if.bottom_y      <= offered_word.bot;
                    in_if.point_x       <= offered_word.px;
                    in_if.point_y       <= offered_word.py;
                    in_if.valid         <= 1'b1;
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk) begin : monitor
        t_snap_res want;
        if (!rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (expected_snaps.size() == 0) begin
                    $error("result word with no snap pending");
                    fail_count++;
                end else begin
                    want = expected_snaps.pop_front();
                    if (out_if.snapped_x !== want.x) begin
                        $error("snapped_x: expected %0d, got %0d", want.x, out_if.snapped_x);
                        fail_count++;
                    end
                    if (out_if.snapped_y !== want.y) begin
                        $error("snapped_y: expected %0d, got %0d", want.y, out_if.snapped_y);
                        fail_count++;
                    end
                    if (out_if.box_index !== want.index) begin
                        $error("box_index: expected %0d, got %0d", want.index,
                               out_if.box_index);
                        fail_count++;
                    end
                    if (out_if.found !== want.found) begin
                        $error("found: expected %0d, got %0d", want.found, out_if.found);
                        fail_count++;
                    end
                end
            end
            out_if.ready <= !rx_hold && ($urandom_range(99) >= recv_gap_pct);
        end
    end

    initial begin
        wait (hold_go);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        rx_hold <= 1'b0;
    end

    function automatic logic [COORD_W-1:0] rand_coord();
        int pick;
        pick = $urandom_range(9);
        if (pick == 0) return '0;
        if (pick == 1) return '1;
        return COORD_W'($urandom_range(255));
    endfunction

    function automatic t_in_word noise_word();
        t_in_word w;
        w.func = 1'($urandom);
        w.slot = SLOT_W'($urandom);
        w.ulx  = rand_coord();
        w.urx  = rand_coord();
        w.llx  = rand_coord();
        w.lrx  = rand_coord();
        w.top  = rand_coord();
        w.bot  = rand_coord();
        w.px   = rand_coord();
        w.py   = rand_coord();
        return w;
    endfunction

    function automatic t_in_word box_word(input int slot, input int top, input int bot,
                                          input int ulx, input int urx,
                                          input int llx, input int lrx);
        t_in_word w;
        w      = noise_word();
        w.func = FUNC_LOAD;
        w.slot = SLOT_W'(slot);
        w.top  = COORD_W'(top);
        w.bot  = COORD_W'(bot);
        w.ulx  = COORD_W'(ulx);
        w.urx  = COORD_W'(urx);
        w.llx  = COORD_W'(llx);
        w.lrx  = COORD_W'(lrx);
        return w;
    endfunction

    function automatic t_in_word point_word(input int x, input int y);
        t_in_word w;
        w      = noise_word();
        w.func = FUNC_SNAP;
        w.px   = COORD_W'(x);
        w.py   = COORD_W'(y);
        return w;
    endfunction

    // Mostly ordered edges; one load in ten keeps fully random corners.
    function automatic t_in_word load_word(input int slot);
        t_in_word w;
        logic [COORD_W-1:0] a, b;
        w      = noise_word();
        w.func = FUNC_LOAD;
        w.slot = SLOT_W'(slot);
        if ($urandom_range(9) != 0) begin
            a = rand_coord();
            b = rand_coord();
            w.top = (a < b) ? a : b;
            w.bot = (a < b) ? b : a;
            a = rand_coord();
            b = rand_coord();
            w.ulx = (a < b) ? a : b;
            w.urx = (a < b) ? b : a;
            a = rand_coord();
            b = rand_coord();
            w.llx = (a < b) ? a : b;
            w.lrx = (a < b) ? b : a;
        end
        return w;
    endfunction

    // Only used once every slot holds a box.
    function automatic t_in_word random_word();
        t_in_word w;
        t_box b;
        int pick;
        pick = $urandom_range(99);
        if (pick < 30) return load_word($urandom_range(BOX_SLOTS - 1));
        w = point_word(rand_coord(), rand_coord());
        if (pick < 55) begin
            // Aim at the middle of a stored box to hit the zero score exit.
            b = box_mem[$urandom_range(BOX_SLOTS - 1)];
            w.px = COORD_W'((int'(b.ulx) + int'(b.urx) + int'(b.llx) + int'(b.lrx)) / 4);
            w.py = COORD_W'((int'(b.top) + int'(b.bot)) / 2);
        end
        return w;
    endfunction

    task automatic wait_idle();
        do @(negedge clk);
        while (pending_words.size() != 0 || in_if.valid || expected_snaps.size() != 0);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_count(input int value);
        @(posedge clk);
        cfg_we      <= 1'b1;
        cfg_wdata   <= COUNT_W'(value);
        box_count_q = value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    initial begin : stimulus
        int phase_counts [PHASES];
        int p, j;
        phase_counts = '{1, 3, 32, 8, 63, 0, 16, 33, 5};
        wait (rst_n === 1'b1);
        @(negedge clk);

        // No boxes in use after reset.
        pending_words.push_back(point_word(0, 0));
        pending_words.push_back(point_word(255, 255));
        // A single box in the far corner: one point is out of reach entirely,
        // the other scores above 8 bits and wraps around.
        pending_words.push_back(box_word(0, 255, 255, 255, 255, 255, 255));
        wait_idle();
        write_count(1);
        pending_words.push_back(point_word(0, 255));
        pending_words.push_back(point_word(0, 0));

        pending_words.push_back(box_word(0, 40, 100, 50, 120, 30, 140));
        pending_words.push_back(box_word(1, 0, 255, 200, 10, 255, 0));
        pending_words.push_back(box_word(2, 0, 0, 0, 0, 0, 0));
        pending_words.push_back(box_word(3, 128, 200, 10, 20, 240, 250));
        pending_words.push_back(box_word(4, 40, 100, 50, 120, 30, 140));
        wait_idle();
        write_count(5);
        pending_words.push_back(point_word(80, 70));
        pending_words.push_back(point_word(80, 10));
        pending_words.push_back(point_word(80, 200));
        pending_words.push_back(point_word(5, 70));
        pending_words.push_back(point_word(250, 70));
        pending_words.push_back(point_word(5, 150));
        pending_words.push_back(point_word(255, 0));
        pending_words.push_back(point_word(0, 255));
        pending_words.push_back(point_word(128, 128));
        pending_words.push_back(point_word(100, 230));
        wait_idle();

        for (j = 0; j < BOX_SLOTS; j++) pending_words.push_back(load_word(j));
        wait_idle();

        for (p = 0; p < PHASES; p++) begin
            if (p < 3) begin
                send_gap_pct = 26;
                recv_gap_pct = 69;
            end else if (p < 6) begin
                send_gap_pct = 69;
                recv_gap_pct = 26;
            end else begin
                send_gap_pct = 0;
                recv_gap_pct = 0;
            end
            write_count(phase_counts[p]);
            if (p == 3) hold_go = 1'b1;
            for (j = 0; j < PHASE_ITEMS; j++) begin
                pending_words.push_back(random_word());
                // Let the block drain completely halfway through one phase.
                if (p == 1 && j == PHASE_ITEMS / 2) wait_idle();
            end
            wait_idle();
        end

        if (fail_count == 0) begin
            $display("[walkbox_point_snap_core] OK");
        end else begin
            $display("[walkbox_point_snap_core] ERROR");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("[walkbox_point_snap_core] ERROR");
        $finish;
    end

endmodule
